[rtl/rhcm_pkg.sv]
// ----------------------------------------------------------------------------
// rhcm_pkg
// Shared types, color stop table and lookup tables for the heat-map color ramp.
// ----------------------------------------------------------------------------
package rhcm_pkg;

  localparam int unsigned StopCount = 8;
  localparam int unsigned SegCount  = StopCount - 1;
  localparam int unsigned LevelMax  = 255;

  // Normalization: level = (dbm + DbmOffset) * 255 / DbmRange
  localparam int          DbmOffset = 115;
  localparam int unsigned DbmRange  = 80;

  localparam logic [7:0] MaskR = 8'hF8;
  localparam logic [7:0] MaskG = 8'hFC;

  typedef logic [2:0] seg_t;
  typedef logic [7:0] level_t;
  typedef logic [2:0][7:0] rgb_t;   // [2] red, [1] green, [0] blue

  typedef enum logic [1:0] {
    CH_BLUE  = 2'd0,
    CH_GREEN = 2'd1,
    CH_RED   = 2'd2
  } chan_e;

  localparam logic [0:StopCount-1][7:0] STOP_POS =
    {8'd0, 8'd42, 8'd86, 8'd126, 8'd164, 8'd198, 8'd226, 8'd255};
  localparam logic [0:StopCount-1][7:0] STOP_R =
    {8'd2, 8'd30, 8'd15, 8'd0, 8'd25, 8'd255, 8'd255, 8'd255};
  localparam logic [0:StopCount-1][7:0] STOP_G =
    {8'd4, 8'd12, 8'd45, 8'd214, 8'd235, 8'd235, 8'd70, 8'd245};
  localparam logic [0:StopCount-1][7:0] STOP_B =
    {8'd14, 8'd105, 8'd230, 8'd255, 8'd116, 8'd20, 8'd10, 8'd255};

  localparam int SegSpan [SegCount] = '{
    int'(STOP_POS[1]) - int'(STOP_POS[0]),
    int'(STOP_POS[2]) - int'(STOP_POS[1]),
    int'(STOP_POS[3]) - int'(STOP_POS[2]),
    int'(STOP_POS[4]) - int'(STOP_POS[3]),
    int'(STOP_POS[5]) - int'(STOP_POS[4]),
    int'(STOP_POS[6]) - int'(STOP_POS[5]),
    int'(STOP_POS[7]) - int'(STOP_POS[6])
  };

  // {segment, fraction} per level
  typedef struct packed {
    seg_t       seg;
    logic [7:0] frac;
  } seg_frac_t;

  typedef seg_frac_t [0:LevelMax] frac_lut_t;

  typedef struct packed {
    logic   valid;
    level_t level;
  } lvl_word_t;

  typedef struct packed {
    logic      valid;
    seg_frac_t sf;
  } sf_word_t;

  // Built at elaboration only.
  function automatic frac_lut_t build_frac_lut();
    frac_lut_t lut;
    int        s;
    int        d;
    int        f;
    lut = '0;
    for (int lv = 0; lv <= int'(LevelMax); lv++) begin
      s = 0;
      for (int i = int'(SegCount); i >= 1; i--) begin
        if (lv <= int'(STOP_POS[i])) s = i - 1;
      end
      d = lv - int'(STOP_POS[s]);
      f = (SegSpan[s] > 0) ? (d * 255) / SegSpan[s] : 0;
      if (f < 0)   f = 0;
      if (f > 255) f = 255;
      lut[lv].seg  = seg_t'(s);
      lut[lv].frac = 8'(f);
    end
    return lut;
  endfunction

  localparam frac_lut_t FRAC_LUT = build_frac_lut();

  function automatic logic [7:0] stop_color(chan_e ch, logic [2:0] idx);
    logic [7:0] c;
    case (ch)
      CH_RED:   c = STOP_R[idx];
      CH_GREEN: c = STOP_G[idx];
      CH_BLUE:  c = STOP_B[idx];
      default:  c = '0;
    endcase
    return c;
  endfunction

  // RGB565, then byte swap
  function automatic logic [15:0] pack_swapped(logic [7:0] r, logic [7:0] g, logic [7:0] b);
    logic [15:0] native;
    native = {r[7:3], g[7:2], b[7:3]};
    return {native[7:0], native[15:8]};
  endfunction

  localparam logic [15:0] WEAK_PIXEL   = pack_swapped(STOP_R[0], STOP_G[0], STOP_B[0]);
  localparam logic [15:0] STRONG_PIXEL =
    pack_swapped(STOP_R[StopCount-1], STOP_G[StopCount-1], STOP_B[StopCount-1]);

endpackage

[rtl/rssi_heatmap_color_map_core.sv]
// ----------------------------------------------------------------------------
// rssi_heatmap_color_map_core
// Signal strength in dBm to a byte-swapped RGB565 heat-map pixel.
// ----------------------------------------------------------------------------
// Usage:
//   Input: drive level_dbm_i and pulse start; the word is taken on any edge
//   where start is high and busy is low. busy stays low, so a new word may
//   be issued every cycle.
//   Output: done_o is high for exactly one cycle with the pixel on pixel_o;
//   the receiver must take it in that cycle.
//   Throughput: one pixel per clock.
//   Pipeline: level scale/clamp, segment and fraction table lookup,
//   per-channel difference multiply, divide-by-255 and add.
//   Reset: rst_ni clears all stage valid bits; words in flight are dropped
//   and no pixel appears until a new word is accepted.
// ----------------------------------------------------------------------------
module rssi_heatmap_color_map_core (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              start,
  output logic              busy,
  input  logic signed [7:0] level_dbm_i,
  output logic              done_o,
  output logic [15:0]       pixel_o
);
  import rhcm_pkg::*;

  lvl_word_t lvl_word;
  sf_word_t  sf_word;
  rgb_t      rgb;
  logic      accept;

  assign busy   = 1'b0;
  assign accept = start && !busy;

  rhcm_level u_level (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .valid_i     (accept),
    .level_dbm_i (level_dbm_i),
    .word_o      (lvl_word)
  );

  rhcm_frac u_frac (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .word_i (lvl_word),
    .word_o (sf_word)
  );

  rhcm_blend u_blend (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .word_i  (sf_word),
    .valid_o (done_o),
    .rgb_o   (rgb)
  );

  assign pixel_o = pack_swapped(rgb[CH_RED], rgb[CH_GREEN], rgb[CH_BLUE]);

`ifndef ASSERT_OFF
  a_latency: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept |-> ##4 done_o)
    else $error("accepted word did not produce a pixel after 4 cycles");

  a_weak_clamp: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (accept && (level_dbm_i <= -8'sd115)) |-> ##4 (pixel_o == WEAK_PIXEL))
    else $error("weak signal did not map to first stop color");

  a_strong_clamp: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (accept && (level_dbm_i > -8'sd35)) |-> ##4 (pixel_o == STRONG_PIXEL))
    else $error("strong signal did not map to last stop color");
`endif

endmodule

[rtl/rhcm_level.sv]
// ----------------------------------------------------------------------------
// rhcm_level
// Stage 1: dBm reading to clamped 0..255 level.
// ----------------------------------------------------------------------------
module rhcm_level (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   valid_i,
  input  logic signed [7:0]      level_dbm_i,
  output rhcm_pkg::lvl_word_t    word_o
);
  import rhcm_pkg::*;

  logic signed [8:0] offs;
  logic [12:0]       scaled;
  level_t            level_d, level_q;
  logic              valid_q;

  // 255/80 reduces to 51/16, so the product is exact below the clamp point
  assign offs   = 9'(level_dbm_i) + 9'(DbmOffset);
  assign scaled = 13'(offs[6:0]) * 13'd51;

  always_comb begin
    if (offs <= 9'sd0) begin
      level_d = '0;
    end else if (offs >= 9'(DbmRange)) begin
      level_d = 8'(LevelMax);
    end else begin
      level_d = scaled[11:4];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    level_q <= level_d;
  end

  assign word_o.valid = valid_q;
  assign word_o.level = level_q;

endmodule

[rtl/rhcm_frac.sv]
// ----------------------------------------------------------------------------
// rhcm_frac
// Stage 2: segment select and in-segment fraction from a constant table.
// ----------------------------------------------------------------------------
module rhcm_frac (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  rhcm_pkg::lvl_word_t   word_i,
  output rhcm_pkg::sf_word_t    word_o
);
  import rhcm_pkg::*;

  seg_frac_t sf_d, sf_q;
  logic      valid_q;

  assign sf_d = FRAC_LUT[word_i.level];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= word_i.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    sf_q <= sf_d;
  end

  assign word_o.valid = valid_q;
  assign word_o.sf    = sf_q;

endmodule

[rtl/rhcm_blend.sv]
// ----------------------------------------------------------------------------
// rhcm_blend
// Stages 3 and 4: per-channel interpolation a + trunc((b-a)*frac/255).
// ----------------------------------------------------------------------------
module rhcm_blend (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  rhcm_pkg::sf_word_t    word_i,
  output logic                  valid_o,
  output rhcm_pkg::rgb_t        rgb_o
);
  import rhcm_pkg::*;

  logic [2:0][15:0] prod_d, prod_q;
  logic [2:0]       neg_d, neg_q;
  rgb_t             base_d, base_q;
  rgb_t             rgb_d, rgb_q;
  logic             valid3_q, valid4_q;

  // stage 3: magnitude of the stop difference times fraction
  always_comb begin
    logic [7:0]        a;
    logic [7:0]        b;
    logic signed [8:0] diff;
    logic [7:0]        mag;
    for (int c = 0; c < 3; c++) begin
      a    = stop_color(chan_e'(c), word_i.sf.seg);
      b    = stop_color(chan_e'(c), word_i.sf.seg + 3'd1);
      diff = $signed({1'b0, b}) - $signed({1'b0, a});
      mag  = diff[8] ? 8'(-diff) : diff[7:0];
      neg_d[c]  = diff[8];
      base_d[c] = a;
      prod_d[c] = 16'(mag) * 16'(word_i.sf.frac);
    end
  end

  // stage 4: x/255 as (x + 1 + (x >> 8)) >> 8, exact for x below 65535
  always_comb begin
    logic [16:0] sum;
    logic [7:0]  q;
    for (int c = 0; c < 3; c++) begin
      sum = 17'(prod_q[c]) + 17'd1 + 17'(prod_q[c][15:8]);
      q   = sum[15:8];
      rgb_d[c] = neg_q[c] ? (base_q[c] - q) : (base_q[c] + q);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid3_q <= 1'b0;
      valid4_q <= 1'b0;
    end else begin
      valid3_q <= word_i.valid;
      valid4_q <= valid3_q;
    end
  end

  always_ff @(posedge clk_i) begin
    prod_q <= prod_d;
    neg_q  <= neg_d;
    base_q <= base_d;
    rgb_q  <= rgb_d;
  end

  assign valid_o = valid4_q;
  assign rgb_o   = rgb_q;

endmodule

[dv/rssi_heatmap_color_map_checker.sv]
// ----------------------------------------------------------------------------
// rssi_heatmap_color_map_checker
// Watches the dBm input and pixel output channels, predicts each heat-map
// pixel and compares results in order; reports a mismatch count to the top.
// ----------------------------------------------------------------------------
module rssi_heatmap_color_map_checker (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              start_i,
  input  logic              busy_i,
  input  logic signed [7:0] level_dbm_i,
  input  logic              done_i,
  input  logic [15:0]       pixel_i,
  output int                mismatch_count_o,
  output int                pending_o
);
  timeunit 1ns;
  timeprecision 1ps;

  localparam int DBM_OFFSET = 115;
  localparam int DBM_SPAN   = 80;

  // Color stops: position and {red, green, blue}
  localparam logic [0:7][7:0] RAMP_POS =
    {8'd0, 8'd42, 8'd86, 8'd126, 8'd164, 8'd198, 8'd226, 8'd255};
  localparam logic [0:7][23:0] RAMP_RGB = {
    {8'd2,   8'd4,   8'd14},
    {8'd30,  8'd12,  8'd105},
    {8'd15,  8'd45,  8'd230},
    {8'd0,   8'd214, 8'd255},
    {8'd25,  8'd235, 8'd116},
    {8'd255, 8'd235, 8'd20},
    {8'd255, 8'd70,  8'd10},
    {8'd255, 8'd245, 8'd255}
  };

  logic [15:0] expected_pixels [$];

  function automatic logic [15:0] heat_pixel(input logic signed [7:0] dbm);
    int          lvl;
    int          seg;
    int          lo;
    int          frac;
    int          a;
    int          b;
    int          v;
    logic [23:0] rgb;
    logic [15:0] native;
    // SV integer division truncates toward zero, as the ramp requires
    lvl = ((int'(dbm) + DBM_OFFSET) * 255) / DBM_SPAN;
    if (lvl < 0) lvl = 0;
    if (lvl > 255) lvl = 255;
    seg = 1;
    while (lvl > int'(RAMP_POS[seg])) seg++;
    lo   = int'(RAMP_POS[seg-1]);
    frac = ((lvl - lo) * 255) / (int'(RAMP_POS[seg]) - lo);
    for (int c = 0; c < 3; c++) begin
      a = int'(RAMP_RGB[seg-1][8*c +: 8]);
      b = int'(RAMP_RGB[seg][8*c +: 8]);
      v = a + ((b - a) * frac) / 255;
      rgb[8*c +: 8] = v[7:0];
    end
    native = {rgb[23:19], rgb[15:10], rgb[7:3]};
    return {native[7:0], native[15:8]};
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    logic [15:0] want;
    if (!rst_ni) begin
      expected_pixels.delete();
      mismatch_count_o = 0;
      pending_o = 0;
    end else begin
      if (done_i === 1'b1) begin
        if (expected_pixels.size() == 0) begin
          mismatch_count_o++;
          $display("%0t: unexpected pixel word, expected none, got %h", $time, pixel_i);
        end else begin
          want = expected_pixels.pop_front();
          if (pixel_i !== want) begin
            mismatch_count_o++;
            $display("%0t: pixel mismatch, expected %h, got %h", $time, want, pixel_i);
          end
        end
      end
      if (start_i === 1'b1 && busy_i === 1'b0)
        expected_pixels.push_back(heat_pixel(level_dbm_i));
      pending_o = expected_pixels.size();
    end
  end

endmodule

[dv/rssi_heatmap_color_map_core_tb.sv]
// ----------------------------------------------------------------------------
// rssi_heatmap_color_map_core_tb
// Drives dBm words into the color ramp core: directed edge and stop cases,
// then random readings with random idle cycles; the checker scores pixels.
// ----------------------------------------------------------------------------
module rssi_heatmap_color_map_core_tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int RANDOM_WORDS = 700;
  localparam int IDLE_PCT     = 18;
  localparam int DRAIN_CYCLES = 8;

  logic              clk;
  logic              rst_n;
  logic              start;
  logic              busy;
  logic signed [7:0] level_dbm;
  logic              done;
  logic [15:0]       pixel;
  int                mismatches;
  int                pending;

  rssi_heatmap_color_map_core dut (
    .clk_i      (clk),
    .rst_ni     (rst_n),
    .start      (start),
    .busy       (busy),
    .level_dbm_i(level_dbm),
    .done_o     (done),
    .pixel_o    (pixel)
  );

  rssi_heatmap_color_map_checker u_checker (
    .clk_i           (clk),
    .rst_ni          (rst_n),
    .start_i         (start),
    .busy_i          (busy),
    .level_dbm_i     (level_dbm),
    .done_i          (done),
    .pixel_i         (pixel),
    .mismatch_count_o(mismatches),
    .pending_o       (pending)
  );

  always begin
    clk = 1'b1;
    #6;
    clk = 1'b0;
    #6;
  end

  initial begin
    #2_400_000;
    $display("Some tests failed");
    $finish;
  end

  // One word; optional random idle cycles first, with junk on the data port
  task automatic send_dbm(input logic signed [7:0] dbm, input bit may_idle);
    if (may_idle) begin
      while ($urandom_range(99) < IDLE_PCT) begin
        start     <= 1'b0;
        level_dbm <= 8'($urandom);
        @(posedge clk);
      end
    end
    start     <= 1'b1;
    level_dbm <= dbm;
    @(posedge clk);
    while (busy) @(posedge clk);
  endtask

  task automatic drain_pixels();
    start <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
  endtask

  // Weak clamp, level 0, stops hit exactly (-88 -> 86, -44 -> 226),
  // neighbors of the stops that are not reachable, strong clamp, sign bits
  logic signed [7:0] directed_dbm [] = '{
    -128, -127, -116, -115, -114, -102, -101, -89, -88, -87, -76, -75,
    -64, -56, -55, -45, -44, -43, -36, -35, -34, -1, 0, 85, 127
  };

  initial begin
    logic signed [7:0] dbm;
    start     <= 1'b0;
    level_dbm <= '0;
    rst_n     = 1'b0;
    repeat (9) @(posedge clk);
    rst_n     <= 1'b1;
    @(posedge clk);

    foreach (directed_dbm[i]) send_dbm(directed_dbm[i], i[0]);
    drain_pixels();

    for (int n = 0; n < RANDOM_WORDS; n++) begin
      // mostly the ramp region, the rest anywhere in the 8-bit range
      if ($urandom_range(99) < 70) dbm = 8'($urandom_range(85) - 118);
      else dbm = 8'($urandom);
      // back-to-back stretch with no idle cycles
      send_dbm(dbm, !(n >= 250 && n < 400));
      if (n == 500) drain_pixels();
    end

    drain_pixels();
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatches == 0 && pending == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule
